FILE: design/mcbc_pkg.sv
// ----------------------------------------------------------------------------
// mcbc_pkg
// Shared types and constants of the multi-channel blink controller.
// ----------------------------------------------------------------------------
package mcbc_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ENB_W    = 4;

  localparam logic [6:0]  DUTY_MAX    = 7'd100;
  // floor(x/100) == (x*RECIP) >> RECIP_SHIFT for every x below 100*65536
  localparam logic [23:0] RECIP       = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  localparam logic [2:0]  REG_CHANNEL_ENABLE = 3'd0;
  localparam logic [3:0]  ENABLE_RESET       = 4'hF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_BLINK = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ON    = 2'd1,
    MODE_OFF   = 2'd2,
    MODE_BLINK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_e;

endpackage

FILE: design/mcbc_on_time.sv
// ----------------------------------------------------------------------------
// mcbc_on_time
// Two-stage on-time unit: duty * period, then divide by 100 by reciprocal.
// ----------------------------------------------------------------------------
module mcbc_on_time
  import mcbc_pkg::*;
(
  input  logic        clk_i,
  input  logic [6:0]  duty_i,
  input  logic [15:0] period_i,
  output logic [15:0] on_ticks_o
);

  logic [22:0] prod_q, prod_d;
  logic [15:0] quot_q, quot_d;
  logic [46:0] scaled;

  assign prod_d = 23'(duty_i) * 23'(period_i);
  assign scaled = 47'(prod_q) * 47'(RECIP);
  assign quot_d = scaled[RECIP_SHIFT +: 16];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quot_q <= quot_d;
  end

  assign on_ticks_o = quot_q;

endmodule

FILE: design/multi_channel_blink_controller.sv
// ----------------------------------------------------------------------------
// multi_channel_blink_controller
// Per-channel steady/blink sequencing of switch outputs over a shared
// on-time unit, walked one channel at a time.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | opcode, channel, level, blink_count, duty, period
//  out     | out_valid/out_ready| drive_levels, blink_active
//  cfg     | APB psel/penable   | channel_enable at 0x0
//
//  Set item: accept, update, result; ignored item: accept, result. Blink
//  start: accept, multiply, divide, update, result. Tick: accept, then for
//  each channel multiply, divide (blinking channels only) and update, then
//  result; the two-stage on-time unit is shared across channels.
//  Reset clears modes, levels and the output beat; enable resets to all ones.
//  A result beat waiting on out_ready stalls the next item at its last cycle.
// ----------------------------------------------------------------------------
module multi_channel_blink_controller
  import mcbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  channel_i,
  input  logic        level_i,
  input  logic [15:0] blink_count_i,
  input  logic [6:0]  duty_percent_i,
  input  logic [15:0] period_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  drive_levels_o,
  output logic [3:0]  blink_active_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  logic [ENB_W-1:0] enable_q;
  logic [CH_W-1:0]  ch_q, ch_d;

  opcode_e     op_q;
  logic        lvl_q;
  logic [15:0] count_q;
  logic [6:0]  duty_q;
  logic [15:0] period_q;
  logic [6:0]  duty_sat;

  mode_e       mode_q   [CHANNELS];
  logic        level_q  [CHANNELS];
  logic        driven_q [CHANNELS];
  logic [16:0] toggles_q[CHANNELS];
  logic [15:0] ttt_q    [CHANNELS];
  logic [6:0]  sduty_q  [CHANNELS];
  logic [15:0] speriod_q[CHANNELS];

  mode_e       mode_d;
  logic        level_d, driven_d;
  logic [16:0] toggles_d;
  logic [15:0] ttt_d, ttt_dec;
  logic [6:0]  sduty_d;
  logic [15:0] speriod_d;
  logic        wr_en;

  logic [CHANNELS-1:0] en_vec;
  logic                en_cur;
  logic                ch_in_range;
  logic                in_fire, out_load, cfg_wr;
  logic                out_valid_q;
  logic [3:0]          drv_q, act_q, drv_nxt, act_nxt;

  logic [6:0]  unit_duty;
  logic [15:0] unit_period, on_ticks;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_CHANNEL_ENABLE) ? 32'(enable_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= ENABLE_RESET;
    end else if (cfg_wr && paddr == REG_CHANNEL_ENABLE) begin
      enable_q <= pwdata[ENB_W-1:0];
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_en
    if (c < ENB_W) begin : g_has
      assign en_vec[c] = enable_q[c];
    end else begin : g_none
      assign en_vec[c] = 1'b0;
    end
  end

  assign en_cur      = en_vec[ch_q];
  assign ch_in_range = {1'b0, channel_i} < 5'(CHANNELS);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign duty_sat    = (duty_percent_i > DUTY_MAX) ? DUTY_MAX : duty_percent_i;

  // shared on-time unit
  assign unit_duty   = (op_q == OP_BLINK) ? duty_q   : sduty_q[ch_q];
  assign unit_period = (op_q == OP_BLINK) ? period_q : speriod_q[ch_q];

  mcbc_on_time u_on_time (
    .clk_i      (clk_i),
    .duty_i     (unit_duty),
    .period_i   (unit_period),
    .on_ticks_o (on_ticks)
  );

  // next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (opcode_i == OP_TICK) begin
            state_d = ST_MUL;
            ch_d    = '0;
          end else if (opcode_i == OP_BLINK && ch_in_range) begin
            state_d = ST_MUL;
            ch_d    = channel_i[CH_W-1:0];
          end else if (opcode_i == OP_SET && ch_in_range) begin
            state_d = ST_APPLY;
            ch_d    = channel_i[CH_W-1:0];
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (op_q == OP_TICK && mode_q[ch_q] != MODE_BLINK) begin
          state_d = ST_APPLY;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (op_q == OP_TICK && ch_q != CH_W'(CHANNELS - 1)) begin
          state_d = ST_MUL;
          ch_d    = ch_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // channel update
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    wr_en      = (state_q == ST_APPLY);
    mode_d     = mode_q[ch_q];
    level_d    = level_q[ch_q];
    driven_d   = driven_q[ch_q];
    toggles_d  = toggles_q[ch_q];
    ttt_d      = ttt_q[ch_q];
    sduty_d    = sduty_q[ch_q];
    speriod_d  = speriod_q[ch_q];
    ttt_dec    = (ttt_q[ch_q] == 16'd0) ? 16'd0 : ttt_q[ch_q] - 16'd1;
    unique case (op_q)
      OP_SET: begin
        level_d = lvl_q;
        mode_d  = lvl_q ? MODE_ON : MODE_OFF;
      end
      OP_BLINK: begin
        level_d   = 1'b1;
        mode_d    = MODE_BLINK;
        toggles_d = {count_q, 1'b0};
        sduty_d   = duty_q;
        speriod_d = period_q;
        ttt_d     = on_ticks;
        if (en_cur) begin
          driven_d = 1'b1;
        end
      end
      OP_TICK: begin
        unique case (mode_q[ch_q])
          MODE_BLINK: begin
            ttt_d = ttt_dec;
            if (ttt_dec == 16'd0 && en_cur) begin
              if (toggles_q[ch_q] != 17'd0) begin
                toggles_d = toggles_q[ch_q] - 17'd1;
                if (toggles_q[ch_q] == 17'd2) begin
                  mode_d = MODE_IDLE;
                end
              end
              level_d  = ~level_q[ch_q];
              driven_d = ~level_q[ch_q];
              ttt_d    = level_q[ch_q] ? speriod_q[ch_q] - on_ticks : on_ticks;
            end
          end
          MODE_ON, MODE_OFF: begin
            if (en_cur) begin
              mode_d   = MODE_IDLE;
              driven_d = (mode_q[ch_q] == MODE_ON);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  for (genvar b = 0; b < 4; b++) begin : g_out
    if (b < CHANNELS) begin : g_ch
      assign drv_nxt[b] = driven_q[b] && en_vec[b];
      assign act_nxt[b] = (mode_q[b] == MODE_BLINK);
    end else begin : g_pad
      assign drv_nxt[b] = 1'b0;
      assign act_nxt[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        mode_q[c]   <= MODE_IDLE;
        level_q[c]  <= 1'b0;
        driven_q[c] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        mode_q[ch_q]   <= mode_d;
        level_q[ch_q]  <= level_d;
        driven_q[ch_q] <= driven_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= opcode_e'(opcode_i);
      lvl_q    <= level_i;
      count_q  <= blink_count_i;
      duty_q   <= duty_sat;
      period_q <= period_ticks_i;
    end
    if (wr_en) begin
      toggles_q[ch_q] <= toggles_d;
      ttt_q[ch_q]     <= ttt_d;
      sduty_q[ch_q]   <= sduty_d;
      speriod_q[ch_q] <= speriod_d;
    end
    if (out_load) begin
      drv_q <= drv_nxt;
      act_q <= act_nxt;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_levels_o = drv_q;
  assign blink_active_o = act_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted item did not start the sequencer");

  a_done_raises_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == ST_IDLE)
    else $error("result beat not presented after completion");

  a_div_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |=> state_q == ST_APPLY && $stable(ch_q))
    else $error("on-time result not consumed by the addressed channel");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV || state_q == ST_APPLY) |-> !in_ready_o)
    else $error("input taken while an item is in progress");
`endif

endmodule

FILE: dv/multi_channel_blink_controller_tb.sv
// ----------------------------------------------------------------------------
// multi_channel_blink_controller_tb
// Drives command beats into the blink controller with random gaps and random
// back-pressure on the result side, and reprograms channel_enable over APB
// between phases. A scoreboard keeps its own copy of every channel's mode,
// level, countdown and budget. It predicts drive_levels and blink_active for
// each accepted command and checks them against the result beats in order.
// ----------------------------------------------------------------------------
module multi_channel_blink_controller_tb
  import mcbc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ENABLE_ADDR   = 3'(4 * REG_CHANNEL_ENABLE);
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 100;

  typedef struct packed {
    opcode_e     opcode;
    logic [3:0]  channel;
    logic        level;
    logic [15:0] blink_count;
    logic [6:0]  duty;
    logic [15:0] period;
  } blink_cmd_t;

  typedef struct packed {
    logic [3:0] drive;
    logic [3:0] active;
  } levels_t;

  class blink_scoreboard;
    mode_e       mode_q    [CHANNELS];
    bit          level_q   [CHANNELS];
    bit          driven_q  [CHANNELS];
    bit [16:0]   toggles_q [CHANNELS];
    bit [15:0]   ticks_q   [CHANNELS];
    bit [6:0]    duty_q    [CHANNELS];
    bit [15:0]   period_q  [CHANNELS];
    bit [3:0]    enable_mask;
    levels_t     expected_levels_q [$];
    int unsigned mismatches;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        mode_q[c]    = MODE_IDLE;
        level_q[c]   = 1'b0;
        driven_q[c]  = 1'b0;
        toggles_q[c] = '0;
        ticks_q[c]   = '0;
        duty_q[c]    = '0;
        period_q[c]  = '0;
      end
      enable_mask = ENABLE_RESET;
      mismatches  = 0;
    endfunction

    function bit enabled(int unsigned c);
      return (c < ENB_W) && enable_mask[c];
    endfunction

    function bit [15:0] on_time(int unsigned c);
      bit [31:0] prod;
      prod = 32'(duty_q[c]) * 32'(period_q[c]) / 32'd100;
      return prod[15:0];
    endfunction

    function void set_enable(bit [3:0] mask);
      enable_mask = mask;
    endfunction

    function int unsigned pending();
      return expected_levels_q.size();
    endfunction

    function void note_command(blink_cmd_t cmd);
      bit [6:0] duty;
      levels_t  lv;
      lv = '0;
      case (cmd.opcode)
        OP_TICK: begin
          for (int c = 0; c < CHANNELS; c++) begin
            case (mode_q[c])
              MODE_BLINK: begin
                if (ticks_q[c] != 0) ticks_q[c]--;
                if (ticks_q[c] == 0 && enabled(c)) begin
                  if (toggles_q[c] != 0) begin
                    toggles_q[c]--;
                    if (toggles_q[c] == 1) mode_q[c] = MODE_IDLE;
                  end
                  level_q[c]  = ~level_q[c];
                  driven_q[c] = level_q[c];
                  ticks_q[c]  = level_q[c] ? on_time(c) : period_q[c] - on_time(c);
                end
              end
              MODE_ON, MODE_OFF: begin
                if (enabled(c)) begin
                  driven_q[c] = (mode_q[c] == MODE_ON);
                  mode_q[c]   = MODE_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        OP_SET: begin
          if (cmd.channel < CHANNELS) begin
            level_q[cmd.channel] = cmd.level;
            mode_q[cmd.channel]  = cmd.level ? MODE_ON : MODE_OFF;
          end
        end
        OP_BLINK: begin
          if (cmd.channel < CHANNELS) begin
            duty = (cmd.duty > DUTY_MAX) ? DUTY_MAX : cmd.duty;
            level_q[cmd.channel]   = 1'b1;
            mode_q[cmd.channel]    = MODE_BLINK;
            toggles_q[cmd.channel] = {cmd.blink_count, 1'b0};
            duty_q[cmd.channel]    = duty;
            period_q[cmd.channel]  = cmd.period;
            ticks_q[cmd.channel]   = on_time(cmd.channel);
            if (enabled(cmd.channel)) driven_q[cmd.channel] = 1'b1;
          end
        end
        default: ;
      endcase
      for (int unsigned c = 0; c < CHANNELS && c < ENB_W; c++) begin
        lv.drive[c]  = driven_q[c] && enabled(c);
        lv.active[c] = (mode_q[c] == MODE_BLINK);
      end
      expected_levels_q.push_back(lv);
    endfunction

    function void check_levels(logic [3:0] drive, logic [3:0] active);
      levels_t exp_lv;
      if (expected_levels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: drive %h active %h", drive, active);
        return;
      end
      exp_lv = expected_levels_q.pop_front();
      if (drive !== exp_lv.drive || active !== exp_lv.active) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected drive %h active %h, got drive %h active %h",
                   exp_lv.drive, exp_lv.active, drive, active);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [3:0]  channel_i;
  logic        level_i;
  logic [15:0] blink_count_i;
  logic [6:0]  duty_percent_i;
  logic [15:0] period_ticks_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  drive_levels_o;
  logic [3:0]  blink_active_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  blink_scoreboard sb = new();
  int unsigned     burst_left = 0;
  logic [3:0]      enable_plan [9];

  multi_channel_blink_controller u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .level_i        (level_i),
    .blink_count_i  (blink_count_i),
    .duty_percent_i (duty_percent_i),
    .period_ticks_i (period_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_levels_o (drive_levels_o),
    .blink_active_o (blink_active_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // beat monitors: command first so a same-edge result pops the older entry
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_command('{opcode_e'(opcode_i), channel_i, level_i, blink_count_i,
                        duty_percent_i, period_ticks_i});
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_levels(drive_levels_o, blink_active_o);
  end

  initial begin
    int unsigned len;
    out_ready_i <= 1'b0;
    forever begin
      if ($urandom_range(99) < 60) begin
        out_ready_i <= 1'b1;
        len = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(20, 1);
      end else begin
        out_ready_i <= 1'b0;
        len = ($urandom_range(14) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 2) begin
      burst_left = $urandom_range(40, 10);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic blink_cmd_t random_cmd();
    blink_cmd_t  cmd;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) cmd.opcode = OP_TICK;
    else if (r < 70) cmd.opcode = OP_SET;
    else if (r < 95) cmd.opcode = OP_BLINK;
    else cmd.opcode = OP_NONE;
    cmd.channel     = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(CHANNELS - 1));
    cmd.level       = 1'($urandom_range(1));
    cmd.blink_count = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    cmd.duty        = 7'($urandom_range(127));
    cmd.period      = ($urandom_range(14) == 0) ? 16'($urandom) : 16'($urandom_range(8));
    return cmd;
  endfunction

  // called at a clock edge; returns at the edge the beat is taken
  task automatic send_cmd(blink_cmd_t cmd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= cmd.opcode;
    channel_i      <= cmd.channel;
    level_i        <= cmd.level;
    blink_count_i  <= cmd.blink_count;
    duty_percent_i <= cmd.duty;
    period_ticks_i <= cmd.period;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_fields(opcode_e op, logic [3:0] ch, logic lvl, logic [15:0] cnt,
                             logic [6:0] duty, logic [15:0] per);
    send_cmd('{op, ch, lvl, cnt, duty, per});
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(logic [3:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= {28'($urandom), mask};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_enable(mask);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OP_TICK;
    channel_i      <= '0;
    level_i        <= 1'b0;
    blink_count_i  <= '0;
    duty_percent_i <= '0;
    period_ticks_i <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    enable_plan = '{4'h0, 4'hF, 4'h5, 4'hA, 4'($urandom), 4'($urandom),
                    4'($urandom), 4'($urandom), 4'hF};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_SET,   4'd0,  1'b1, 16'd0,     7'd0,   16'd0);
    send_fields(OP_SET,   4'd3,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_BLINK, 4'd1,  1'b0, 16'd1,     7'd50,  16'd2);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    // duty beyond 100 saturates; endless budget
    send_fields(OP_BLINK, 4'd2,  1'b1, 16'd0,     7'd127, 16'hFFFF);
    // zero on-time and zero period
    send_fields(OP_BLINK, 4'd3,  1'b0, 16'hFFFF,  7'd0,   16'd0);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_NONE,  4'hF,  1'b1, 16'hFFFF,  7'h7F,  16'hFFFF);
    send_fields(OP_SET,   4'd4,  1'b1, 16'd0,     7'd0,   16'd0);
    send_fields(OP_BLINK, 4'hF,  1'b1, 16'd5,     7'd50,  16'd4);
    send_fields(OP_SET,   4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_TICK,  4'd0,  1'b0, 16'd0,     7'd0,   16'd0);
    send_fields(OP_BLINK, 4'd0,  1'b1, 16'd2,     7'd100, 16'd1);
    repeat (4) send_fields(OP_TICK, 4'd0, 1'b0, 16'd0, 7'd0, 16'd0);
    send_fields(OP_SET,   4'd2,  1'b0, 16'hFFFF,  7'h7F,  16'hFFFF);
    send_fields(OP_TICK,  4'hF,  1'b1, 16'hFFFF,  7'h7F,  16'hFFFF);
    wait_idle();

    foreach (enable_plan[p]) begin
      write_enable(enable_plan[p]);
      repeat (PHASE_ITEMS) send_cmd(random_cmd());
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
